@@ hw/rtl/backslash_escape_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// backslash escape decoder assertion macros
// shared property wrappers, clocked on clock and quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_ASSERT_SVH

// property that must hold at every edge out of reset
`define BSED_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// property that must hold on the edge after the cause
`define BSED_ASSERT_NEXT(label, cause, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (prop)) \
      else $error(msg);

`endif

@@ hw/rtl/bsed_pkg.sv @@
// ----------------------------------------------------------------------------
// bsed_pkg
// types, character codes and helper functions of the backslash escape decoder
// ----------------------------------------------------------------------------
package bsed_pkg;

   localparam int GROUP_BYTES = 5;
   localparam int CNT_W       = $clog2(GROUP_BYTES + 1);

   // escape state codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_ESC     = 3'd1;
   localparam logic [2:0] MODE_HEX     = 3'd2;
   localparam logic [2:0] MODE_UNI     = 3'd3;
   localparam logic [2:0] MODE_OCT     = 3'd4;
   localparam logic [2:0] MODE_SWALLOW = 3'd5;

   localparam logic [CNT_W-1:0] HEX_DIGITS = CNT_W'(2);
   localparam logic [CNT_W-1:0] UNI_DIGITS = CNT_W'(4);
   localparam logic [CNT_W-1:0] OCT_DIGITS = CNT_W'(3);
   localparam logic [CNT_W-1:0] RAW_DEPTH  = CNT_W'(3);

   // character codes
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LOW_A     = 8'h61;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_V     = 8'h76;
   localparam logic [7:0] CH_LOW_X     = 8'h78;
   localparam logic [7:0] CH_LOW_U     = 8'h75;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOW_Z_HEX = 8'h66;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;

   localparam logic [7:0] CTL_BEL = 8'h07;
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_HT  = 8'h09;
   localparam logic [7:0] CTL_VT  = 8'h0B;

   // utf-8 encoding
   localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF8_CONT   = 8'h80;
   localparam logic [7:0]  UTF8_MASK   = 8'h3F;
   localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
   localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;

   // all result beats caused by one input beat
   typedef struct packed {
      logic [GROUP_BYTES-1:0][7:0] data;
      logic [CNT_W-1:0]            count;
      logic                        word_end;
   } group_type;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b1, 4'(c - CH_ZERO)};
      end else if (c >= CH_LOW_A && c <= CH_LOW_Z_HEX) begin
         r = {1'b1, 4'(c - CH_LOW_A + 8'd10)};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
      end
      return r;
   endfunction

   function automatic group_type group_put(input group_type g, input logic [7:0] b);
      group_type r;
      r = g;
      if (r.count < CNT_W'(GROUP_BYTES)) begin
         r.data[r.count] = b;
         r.count         = r.count + CNT_W'(1);
      end
      return r;
   endfunction

   function automatic group_type group_put_utf8(input group_type g, input logic [15:0] v);
      group_type r;
      r = g;
      if (v < UTF8_LIMIT1) begin
         r = group_put(r, v[7:0]);
      end else if (v < UTF8_LIMIT2) begin
         r = group_put(r, UTF8_LEAD2 | {3'b000, v[10:6]});
         r = group_put(r, UTF8_CONT | ({2'b00, v[5:0]} & UTF8_MASK));
      end else begin
         r = group_put(r, UTF8_LEAD3 | {4'b0000, v[15:12]});
         r = group_put(r, UTF8_CONT | ({2'b00, v[11:6]} & UTF8_MASK));
         r = group_put(r, UTF8_CONT | ({2'b00, v[5:0]} & UTF8_MASK));
      end
      return r;
   endfunction

   // bytes a pending escape stands for when it cannot be extended
   function automatic group_type group_flush(
      input group_type        g,
      input logic [2:0]       mode,
      input logic [15:0]      value,
      input logic [2:0]       count,
      input logic [2:0][7:0]  raw
   );
      group_type r;
      int        i;
      r = g;
      unique case (mode)
         MODE_ESC: r = group_put(r, CH_BACKSLASH);
         MODE_HEX: r = group_put(r, (count == '0) ? CH_LOW_X : value[7:0]);
         MODE_UNI: begin
            r = group_put(r, CH_LOW_U);
            for (i = 0; i < 3; i++) begin
               if (3'(i) < count) begin
                  r = group_put(r, raw[i]);
               end
            end
         end
         MODE_OCT:     r = group_put(r, value[7:0]);
         MODE_SWALLOW: r = group_put(r, CH_SPACE);
         default: ;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/backslash_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// decodes backslash escapes in a byte stream, one word at a time
//
// input: raw bytes with req_in_end on the final byte of a word, written like
// a queue: a beat goes in on an edge with push high and full low. one byte
// is taken every cycle while full stays low.
// output: read like a queue: rsp_out_byte, rsp_run_last and rsp_word_end are
// valid while empty is low, and a beat leaves on an edge with pop high.
// each input byte gives zero to five result beats; rsp_run_last marks the
// last of them and rsp_word_end the last beat of a word.
// the group of a byte is written into the group queue on the edge that
// took it, then moves to the output register of the back end. results
// leave at one beat per cycle while pop is high and empty is low.
// the escape state machine runs one byte per cycle while full is low; its
// result groups wait in a GROUP_QUEUE_DEPTH deep queue. when the reader
// stalls the queue fills and full rises until beats are popped again.
// reset clears the escape state, empties the group queue and output register;
// the first byte may be pushed in the cycle after reset falls.
// ----------------------------------------------------------------------------
module backslash_escape_decoder
   import bsed_pkg::*;
#(
   parameter int GROUP_QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_word_end
);

   group_type grp;
   logic      grp_valid;
   group_type head;
   logic      head_valid;
   logic      take;

   bsed_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .in_byte   (req_in_byte),
      .in_end    (req_in_end),
      .grp       (grp),
      .grp_valid (grp_valid)
   );

   bsed_queue #(
      .DEPTH (GROUP_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_valid),
      .push_data  (grp),
      .full       (full),
      .take       (take),
      .head       (head),
      .head_valid (head_valid)
   );

   bsed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .take       (take),
      .empty      (empty),
      .pop        (pop),
      .out_byte   (rsp_out_byte),
      .run_last   (rsp_run_last),
      .word_end   (rsp_word_end)
   );

endmodule

@@ hw/rtl/bsed_front.sv @@
// ----------------------------------------------------------------------------
// bsed_front
// escape state machine: a raw byte a cycle if not full; builds its result group
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_assert.svh"

module bsed_front
   import bsed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] in_byte,
   input  logic       in_end,
   output group_type  grp,
   output logic       grp_valid
);

   logic            accept;
   logic [2:0]      mode_ff, mode_in;
   logic [15:0]     value_ff, value_in;
   logic [2:0]      count_ff, count_in;
   logic [2:0][7:0] raw_ff, raw_in;
   logic [4:0]      hex;
   logic            is_oct;
   logic            fresh;
   group_type       g;

   assign accept = push && !full;
   assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

   always_comb begin
      hex        = hex_decode(in_byte);
      g          = '0;
      g.word_end = in_end;
      mode_in    = mode_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      raw_in     = raw_ff;
      fresh      = 1'b0;

      unique case (mode_ff)
         MODE_ESC: begin
            mode_in  = MODE_IDLE;
            value_in = '0;
            count_in = '0;
            unique case (in_byte)
               CH_LOW_A:   g = group_put(g, CTL_BEL);
               CH_LOW_B:   g = group_put(g, CTL_BS);
               CH_LOW_F:   g = group_put(g, CTL_FF);
               CH_LOW_N:   g = group_put(g, CTL_LF);
               CH_LOW_R:   g = group_put(g, CTL_CR);
               CH_LOW_T:   g = group_put(g, CTL_HT);
               CH_LOW_V:   g = group_put(g, CTL_VT);
               CH_NEWLINE: mode_in = MODE_SWALLOW;
               CH_LOW_X:   mode_in = MODE_HEX;
               CH_LOW_U:   mode_in = MODE_UNI;
               default: begin
                  if (is_oct) begin
                     mode_in  = MODE_OCT;
                     value_in = {13'd0, in_byte[2:0]};
                     count_in = 3'd1;
                  end else begin
                     g = group_put(g, in_byte);
                  end
               end
            endcase
         end
         MODE_HEX: begin
            if (hex[4]) begin
               value_in = {value_ff[11:0], hex[3:0]};
               count_in = count_ff + 3'd1;
               if (count_in >= HEX_DIGITS) begin
                  g        = group_put(g, value_in[7:0]);
                  mode_in  = MODE_IDLE;
                  value_in = '0;
                  count_in = '0;
               end
            end else begin
               g        = group_flush(g, mode_ff, value_ff, count_ff, raw_ff);
               mode_in  = MODE_IDLE;
               value_in = '0;
               count_in = '0;
               fresh    = 1'b1;
            end
         end
         MODE_UNI: begin
            if (hex[4]) begin
               if (count_ff < RAW_DEPTH) begin
                  raw_in[count_ff[1:0]] = in_byte;
               end
               value_in = {value_ff[11:0], hex[3:0]};
               count_in = count_ff + 3'd1;
               if (count_in >= UNI_DIGITS) begin
                  g        = group_put_utf8(g, value_in);
                  mode_in  = MODE_IDLE;
                  value_in = '0;
                  count_in = '0;
               end
            end else begin
               g        = group_flush(g, mode_ff, value_ff, count_ff, raw_ff);
               mode_in  = MODE_IDLE;
               value_in = '0;
               count_in = '0;
               fresh    = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               value_in = {value_ff[12:0], in_byte[2:0]};
               count_in = count_ff + 3'd1;
               if (count_in >= OCT_DIGITS) begin
                  g        = group_put(g, value_in[7:0]);
                  mode_in  = MODE_IDLE;
                  value_in = '0;
                  count_in = '0;
               end
            end else begin
               g        = group_flush(g, mode_ff, value_ff, count_ff, raw_ff);
               mode_in  = MODE_IDLE;
               value_in = '0;
               count_in = '0;
               fresh    = 1'b1;
            end
         end
         MODE_SWALLOW: begin
            if (in_byte != CH_SPACE && in_byte != CH_TAB) begin
               g        = group_flush(g, mode_ff, value_ff, count_ff, raw_ff);
               mode_in  = MODE_IDLE;
               value_in = '0;
               count_in = '0;
               fresh    = 1'b1;
            end
         end
         default: begin
            mode_in  = MODE_IDLE;
            value_in = '0;
            count_in = '0;
            fresh    = 1'b1;
         end
      endcase

      // byte in idle mode or one that ends an escape is handled as a plain byte
      if (fresh) begin
         if (in_byte == CH_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            g = group_put(g, in_byte);
         end
      end

      if (in_end) begin
         if (mode_in != MODE_IDLE) begin
            g = group_flush(g, mode_in, value_in, count_in, raw_in);
         end
         mode_in  = MODE_IDLE;
         value_in = '0;
         count_in = '0;
      end

      grp       = g;
      grp_valid = accept && (g.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         value_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff <= raw_in;
      end
   end

   `BSED_ASSERT(a_mode_legal, mode_ff <= MODE_SWALLOW, "escape mode out of range")
   `BSED_ASSERT(a_idle_no_digits, (mode_ff == MODE_IDLE) |-> (count_ff == '0), "digits left while idle")
   `BSED_ASSERT_NEXT(a_end_clears, accept && in_end, mode_ff == MODE_IDLE && count_ff == '0, "escape pending after word end")

endmodule

@@ hw/rtl/bsed_queue.sv @@
// ----------------------------------------------------------------------------
// bsed_queue
// short queue of result groups between the escape front and the beat back end
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_assert.svh"

module bsed_queue
   import bsed_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      take,
   output group_type head,
   output logic      head_valid
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   group_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full       = (fill_ff == FILL_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !take) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (take && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BSED_ASSERT(a_no_overflow, push |-> !full, "group written into a full queue")
   `BSED_ASSERT(a_no_underflow, take |-> head_valid, "group taken from an empty queue")

endmodule

@@ hw/rtl/bsed_back.sv @@
// ----------------------------------------------------------------------------
// bsed_back
// holds one result group, hands its bytes out one beat per cycle while popped
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_assert.svh"

module bsed_back
   import bsed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  group_type  head,
   input  logic       head_valid,
   output logic       take,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic       run_last,
   output logic       word_end
);

   group_type        cur_ff, cur_in;
   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             last;
   logic             done;

   assign empty    = !valid_ff;
   assign last     = (idx_ff == cur_ff.count - CNT_W'(1));
   assign done     = pop && valid_ff && last;
   assign take     = head_valid && (!valid_ff || done);
   assign out_byte = cur_ff.data[idx_ff];
   assign run_last = last;
   assign word_end = last && cur_ff.word_end;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      priority if (take) begin
         cur_in   = head;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (pop && valid_ff) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `BSED_ASSERT(a_group_nonempty, valid_ff |-> (cur_ff.count != '0 && idx_ff < cur_ff.count), "beat index outside held group")
   `BSED_ASSERT(a_take_nonempty, take |-> (head.count != '0), "empty group reached back end")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for backslash_escape_decoder
// drives raw word bytes through the push/full side and pops decoded beats on
// the empty/pop side. a scoreboard keeps its own copy of the escape state,
// predicts the decoded beats of every accepted byte and checks each popped
// beat against the oldest prediction. a short directed run covers the escape
// forms and corner cases, then random words with mostly well-formed escapes
// run under three idle mixes on both sides.
// ----------------------------------------------------------------------------
module testbench
   import bsed_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       word_end;
   } decoded_beat_type;

   class decode_board;
      logic [2:0]  mode;
      logic [15:0] value;
      logic [2:0]  count;
      logic [7:0]  raw [3];
      logic [7:0]  burst [$];
      decoded_beat_type pending_beats [$];
      int          errors;

      function new();
         mode   = MODE_IDLE;
         value  = '0;
         count  = '0;
         errors = 0;
         foreach (raw[i]) raw[i] = '0;
      endfunction

      function void emit(logic [7:0] b);
         if (burst.size() < GROUP_BYTES) burst.push_back(b);
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
         if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
         if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
         return -1;
      endfunction

      function void to_idle();
         mode  = MODE_IDLE;
         value = '0;
         count = '0;
      endfunction

      function void flush_escape();
         case (mode)
            MODE_ESC: emit(CH_BACKSLASH);
            MODE_HEX: emit((count == 3'd0) ? CH_LOW_X : value[7:0]);
            MODE_UNI: begin
               emit(CH_LOW_U);
               for (int i = 0; i < 3; i++) begin
                  if (i < count) emit(raw[i]);
               end
            end
            MODE_OCT: emit(value[7:0]);
            MODE_SWALLOW: emit(CH_SPACE);
            default: ;
         endcase
         to_idle();
      endfunction

      function void feed_byte(logic [7:0] b);
         int h;
         h = hex_digit(b);
         case (mode)
            MODE_ESC: begin
               to_idle();
               case (b)
                  CH_LOW_A: emit(CTL_BEL);
                  CH_LOW_B: emit(CTL_BS);
                  CH_LOW_F: emit(CTL_FF);
                  CH_LOW_N: emit(CTL_LF);
                  CH_LOW_R: emit(CTL_CR);
                  CH_LOW_T: emit(CTL_HT);
                  CH_LOW_V: emit(CTL_VT);
                  CH_NEWLINE: mode = MODE_SWALLOW;
                  CH_LOW_X: mode = MODE_HEX;
                  CH_LOW_U: mode = MODE_UNI;
                  default: begin
                     if (b >= CH_ZERO && b <= CH_SEVEN) begin
                        mode  = MODE_OCT;
                        value = 16'(b - CH_ZERO);
                        count = 3'd1;
                     end else begin
                        emit(b);
                     end
                  end
               endcase
               return;
            end
            MODE_HEX: begin
               if (h >= 0) begin
                  value = {value[11:0], h[3:0]};
                  count++;
                  if (count >= 3'd2) begin
                     emit(value[7:0]);
                     to_idle();
                  end
                  return;
               end
               flush_escape();
            end
            MODE_UNI: begin
               if (h >= 0) begin
                  if (count < 3'd3) raw[count] = b;
                  value = {value[11:0], h[3:0]};
                  count++;
                  if (count >= 3'd4) begin
                     if (value < UTF8_LIMIT1) begin
                        emit(value[7:0]);
                     end else if (value < UTF8_LIMIT2) begin
                        emit(UTF8_LEAD2 | {3'b000, value[10:6]});
                        emit(UTF8_CONT | {2'b00, value[5:0]});
                     end else begin
                        emit(UTF8_LEAD3 | {4'b0000, value[15:12]});
                        emit(UTF8_CONT | {2'b00, value[11:6]});
                        emit(UTF8_CONT | {2'b00, value[5:0]});
                     end
                     to_idle();
                  end
                  return;
               end
               flush_escape();
            end
            MODE_OCT: begin
               if (b >= CH_ZERO && b <= CH_SEVEN) begin
                  value = {value[12:0], 3'(b - CH_ZERO)};
                  count++;
                  if (count >= 3'd3) begin
                     emit(value[7:0]);
                     to_idle();
                  end
                  return;
               end
               flush_escape();
            end
            MODE_SWALLOW: begin
               if (b == CH_SPACE || b == CH_TAB) return;
               flush_escape();
            end
            default: to_idle();
         endcase
         if (b == CH_BACKSLASH) mode = MODE_ESC;
         else emit(b);
      endfunction

      // predicts the decoded beats of one accepted raw byte
      function void take_raw(logic [7:0] b, logic word_last);
         decoded_beat_type beat;
         burst.delete();
         feed_byte(b);
         if (word_last && mode != MODE_IDLE) flush_escape();
         if (word_last) to_idle();
         foreach (burst[k]) begin
            beat.data     = burst[k];
            beat.run_last = (k == burst.size() - 1);
            beat.word_end = beat.run_last && word_last;
            pending_beats.push_back(beat);
         end
      endfunction

      function void check_decoded(logic [7:0] data, logic run_last, logic word_end);
         decoded_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected rsp beat: out_byte %h run_last %b word_end %b",
                   data, run_last, word_end);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         if (data !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, data);
            errors++;
         end
         if (run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last);
            errors++;
         end
         if (word_end !== want.word_end) begin
            $error("word_end: expected %b, got %b", want.word_end, word_end);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_beats.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_end = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_word_end;

   decode_board board = new();
   int send_idle_pct = 18;
   int pop_idle_pct = 64;
   int sent_items = 0;
   int stall_cycles = 0;

   backslash_escape_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_in_byte  (req_in_byte),
      .req_in_end   (req_in_end),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_word_end (rsp_word_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) board.check_decoded(rsp_out_byte, rsp_run_last, rsp_word_end);
         pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("testbench: FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic word_last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_in_byte <= b;
      req_in_end  <= word_last;
      do @(posedge clock); while (full);
      board.take_raw(b, word_last);
      sent_items++;
   endtask

   task automatic send_text(input string s, input logic word_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], word_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] pick_hex();
      string hexset;
      hexset = "0123456789abcdefABCDEF";
      if ($urandom_range(2) == 0) return CH_ZERO;
      return hexset[$urandom_range(21)];
   endfunction

   task automatic send_word();
      logic [7:0] text [$];
      string      simple;
      int         n_tok;
      int         digits;
      simple = "abfnrtv\\\"{}[]$";
      n_tok = $urandom_range(6, 1);
      repeat (n_tok) begin
         case ($urandom_range(9))
            0, 1: text.push_back(8'($urandom_range(255)));
            2: begin
               text.push_back(CH_BACKSLASH);
               text.push_back(simple[$urandom_range(simple.len() - 1)]);
            end
            3: begin
               text.push_back(CH_BACKSLASH);
               text.push_back(CH_LOW_X);
               digits = $urandom_range(2);
               repeat (digits) text.push_back(pick_hex());
            end
            4, 5: begin
               text.push_back(CH_BACKSLASH);
               text.push_back(CH_LOW_U);
               digits = ($urandom_range(3) == 0) ? $urandom_range(3) : 4;
               repeat (digits) text.push_back(pick_hex());
            end
            6: begin
               text.push_back(CH_BACKSLASH);
               digits = $urandom_range(3, 1);
               repeat (digits) text.push_back(CH_ZERO + 8'($urandom_range(7)));
            end
            7: begin
               text.push_back(CH_BACKSLASH);
               text.push_back(CH_NEWLINE);
               digits = $urandom_range(3);
               repeat (digits) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            end
            8: begin
               text.push_back(CH_BACKSLASH);
               text.push_back(8'($urandom_range(255)));
            end
            default: text.push_back(CH_BACKSLASH);
         endcase
      end
      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("\\n", 1'b0);
      send_text("\\xg", 1'b0);
      send_text("\\uabcz", 1'b0);
      send_text("\\777", 1'b0);
      send_text("\\\n \tq", 1'b0);
      send_text("\\x4", 1'b1);
      send_text("\\", 1'b1);

      while (sent_items < 150) send_word();
      drain_results();

      send_idle_pct = 64;
      pop_idle_pct  = 18;
      while (sent_items < 300) send_word();
      drain_results();

      send_idle_pct = 0;
      pop_idle_pct  = 0;
      while (sent_items < 450) send_word();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bsed_pkg.sv
hw/rtl/bsed_front.sv
hw/rtl/bsed_queue.sv
hw/rtl/bsed_back.sv
hw/rtl/backslash_escape_decoder.sv
tb/testbench.sv
